@@ rtl/pmdec_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the parity-matrix codec.
// Used by every stage module and the top level; depends on nothing else.
package pmdec_pkg;

    localparam int CODE_LEN   = 16;
    localparam int DATA_LEN   = 8;
    localparam int CHECK_ROWS = 8;

    localparam logic [1:0] ST_CLEAN  = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_DOUBLE = 2'd2;
    localparam logic [1:0] ST_UNCORR = 2'd3;

    localparam logic       FUNC_ENCODE = 1'b0;
    localparam logic       FUNC_DECODE = 1'b1;

    localparam logic [4:0] POS_NONE = 5'd16;

    typedef logic [CHECK_ROWS-1:0][CODE_LEN-1:0] t_matrix;

    typedef struct packed {
        logic                func;
        logic [DATA_LEN-1:0] data_byte;
        logic [CODE_LEN-1:0] received_word;
    } t_in_item;

    typedef struct packed {
        logic [CODE_LEN-1:0] code_word;
        logic [DATA_LEN-1:0] decoded_byte;
        logic [1:0]          status;
        logic [4:0]          first_position;
        logic [4:0]          second_position;
    } t_result;

    // After the syndrome stage.
    typedef struct packed {
        logic                  valid;
        logic                  clean;
        logic [CODE_LEN-1:0]   word;
        logic [CHECK_ROWS-1:0] syn;
    } t_s1;

    // After the column compare stage. Vector bit p stands for position p.
    typedef struct packed {
        logic                              valid;
        logic                              clean;
        logic [CODE_LEN-1:0]               word;
        logic [CODE_LEN-1:0]               single_hit;
        logic [CODE_LEN-1:0][CODE_LEN-1:0] pair_hit;
    } t_s2;

    // After the per-row priority stage.
    typedef struct packed {
        logic                     valid;
        logic                     clean;
        logic [CODE_LEN-1:0]      word;
        logic                     single_any;
        logic [3:0]               single_pos;
        logic [CODE_LEN-1:0]      row_any;
        logic [CODE_LEN-1:0][3:0] row_b;
    } t_s3;

    // Lowest set bit of a 16-bit vector; 0 when the vector is empty.
    function automatic logic [3:0] first_set16(input logic [CODE_LEN-1:0] v);
        logic [3:0] idx;
        idx = 4'd0;
        for (int k = CODE_LEN - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = 4'(k);
            end
        end
        return idx;
    endfunction

    // Column of the matrix at position p; bit i is row i.
    function automatic logic [CHECK_ROWS-1:0] column_at(input t_matrix m,
                                                        input logic [3:0] p);
        logic [CHECK_ROWS-1:0] c;
        for (int i = 0; i < CHECK_ROWS; i++) begin
            c[i] = m[i][~p];
        end
        return c;
    endfunction

endpackage

@@ rtl/pmdec_syndrome.sv @@
`timescale 1ns / 1ps
// Stage one: builds the codeword in encode mode and the syndrome in decode mode.
// Depends on pmdec_pkg.
module pmdec_syndrome (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pmdec_pkg::t_in_item i_item,
    input  pmdec_pkg::t_matrix i_rows,
    output pmdec_pkg::t_s1     o_s1
);

    pmdec_pkg::t_s1 r_s1;
    pmdec_pkg::t_s1 n_s1;
    logic [pmdec_pkg::CHECK_ROWS-1:0] w_check;
    logic [pmdec_pkg::CHECK_ROWS-1:0] w_syn;

    always_comb begin
        for (int i = 0; i < pmdec_pkg::CHECK_ROWS; i++) begin
            w_check[pmdec_pkg::CHECK_ROWS-1-i] = ^(i_item.data_byte & i_rows[i][15:8]);
            w_syn[i] = ^(i_item.received_word & i_rows[i]);
        end
        n_s1.valid = i_valid;
        if (i_item.func == pmdec_pkg::FUNC_ENCODE) begin
            n_s1.word  = {i_item.data_byte, w_check};
            n_s1.syn   = '0;
            n_s1.clean = 1'b1;
        end else begin
            n_s1.word  = i_item.received_word;
            n_s1.syn   = w_syn;
            n_s1.clean = (w_syn == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

@@ rtl/pmdec_match.sv @@
`timescale 1ns / 1ps
// Stage two: compares the syndrome with every column and every column pair.
// Depends on pmdec_pkg.
module pmdec_match (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmdec_pkg::t_s1     i_s1,
    input  pmdec_pkg::t_matrix i_rows,
    output pmdec_pkg::t_s2     o_s2
);

    pmdec_pkg::t_s2 r_s2;
    pmdec_pkg::t_s2 n_s2;
    logic [pmdec_pkg::CODE_LEN-1:0][pmdec_pkg::CHECK_ROWS-1:0] w_col;

    always_comb begin
        for (int p = 0; p < pmdec_pkg::CODE_LEN; p++) begin
            w_col[p] = pmdec_pkg::column_at(i_rows, 4'(p));
        end
        n_s2.valid = i_s1.valid;
        n_s2.clean = i_s1.clean;
        n_s2.word  = i_s1.word;
        for (int a = 0; a < pmdec_pkg::CODE_LEN; a++) begin
            n_s2.single_hit[a] = (w_col[a] == i_s1.syn);
            for (int b = 0; b < pmdec_pkg::CODE_LEN; b++) begin
                n_s2.pair_hit[a][b] = (b > a) && ((w_col[a] ^ w_col[b]) == i_s1.syn);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

@@ rtl/pmdec_select.sv @@
`timescale 1ns / 1ps
// Stage three: finds the first matching column and, for each first position,
// the first matching partner. Depends on pmdec_pkg.
module pmdec_select (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmdec_pkg::t_s2 i_s2,
    output pmdec_pkg::t_s3 o_s3
);

    pmdec_pkg::t_s3 r_s3;
    pmdec_pkg::t_s3 n_s3;

    always_comb begin
        n_s3.valid      = i_s2.valid;
        n_s3.clean      = i_s2.clean;
        n_s3.word       = i_s2.word;
        n_s3.single_any = |i_s2.single_hit;
        n_s3.single_pos = pmdec_pkg::first_set16(i_s2.single_hit);
        for (int a = 0; a < pmdec_pkg::CODE_LEN; a++) begin
            n_s3.row_any[a] = |i_s2.pair_hit[a];
            n_s3.row_b[a]   = pmdec_pkg::first_set16(i_s2.pair_hit[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

@@ rtl/pmdec_fix.sv @@
`timescale 1ns / 1ps
// Stage four: picks the correction, flips the bits and registers the result.
// Depends on pmdec_pkg.
module pmdec_fix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmdec_pkg::t_s3    i_s3,
    output logic              o_valid,
    output pmdec_pkg::t_result o_result
);

    logic               r_valid;
    pmdec_pkg::t_result r_result;
    pmdec_pkg::t_result n_result;
    logic [3:0]                   w_pair_a;
    logic [3:0]                   w_pair_b;
    logic [pmdec_pkg::CODE_LEN-1:0] w_word;

    always_comb begin
        w_pair_a = pmdec_pkg::first_set16(i_s3.row_any);
        w_pair_b = i_s3.row_b[w_pair_a];
        w_word   = i_s3.word;
        n_result.status          = pmdec_pkg::ST_CLEAN;
        n_result.first_position  = pmdec_pkg::POS_NONE;
        n_result.second_position = pmdec_pkg::POS_NONE;
        if (i_s3.clean) begin
            n_result.status = pmdec_pkg::ST_CLEAN;
        end else if (i_s3.single_any) begin
            n_result.status         = pmdec_pkg::ST_SINGLE;
            n_result.first_position = {1'b0, i_s3.single_pos};
            w_word[~i_s3.single_pos] = ~i_s3.word[~i_s3.single_pos];
        end else if (|i_s3.row_any) begin
            n_result.status          = pmdec_pkg::ST_DOUBLE;
            n_result.first_position  = {1'b0, w_pair_a};
            n_result.second_position = {1'b0, w_pair_b};
            w_word[~w_pair_a] = ~i_s3.word[~w_pair_a];
            w_word[~w_pair_b] = ~i_s3.word[~w_pair_b];
        end else begin
            n_result.status = pmdec_pkg::ST_UNCORR;
        end
        n_result.code_word    = w_word;
        n_result.decoded_byte = w_word[15:8];
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s3.valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/parity_matrix_double_error_codec.sv @@
`timescale 1ns / 1ps
// Top level of the configurable (16,8) double-error-correcting codec.
// Depends on pmdec_pkg and the four stage modules.
//
// A new word may be started in every clock cycle: busy is always low, so a
// beat is taken whenever start is high. Each beat produces exactly one result
// beat, marked by o_done. The four register stages (syndrome, column compare,
// per-row priority, fix) lie between the accepted word and o_done, and allow
// one word per cycle. The receiver cannot stall, so a result is shown for
// exactly one cycle and must be captured then. The eight matrix rows are
// written through the plain write port and should be changed only while no
// word is in flight; all rows reset to zero.
module parity_matrix_double_error_codec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pmdec_pkg::t_in_item i_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic                o_done,
    output pmdec_pkg::t_result  o_result
);

    // Parity-check matrix: row i, bit 15 is codeword position 0.
    pmdec_pkg::t_matrix r_rows;
    pmdec_pkg::t_s1     w_s1;
    pmdec_pkg::t_s2     w_s2;
    pmdec_pkg::t_s3     w_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else if (i_cfg_we) begin
            r_rows[i_cfg_idx] <= i_cfg_data;
        end
    end

    // The pipeline never holds off an incoming beat.
    assign busy = 1'b0;

    pmdec_syndrome u_syndrome (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .i_rows  (r_rows),
        .o_s1    (w_s1)
    );

    pmdec_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (w_s1),
        .i_rows  (r_rows),
        .o_s2    (w_s2)
    );

    pmdec_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (w_s2),
        .o_s3    (w_s3)
    );

    pmdec_fix u_fix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s3     (w_s3),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    // Every accepted beat comes out as an o_done result at the end of the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("accepted beat did not produce a result");

    // A clean word reports no flipped position.
    a_clean_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == pmdec_pkg::ST_CLEAN) |->
        (o_result.first_position == pmdec_pkg::POS_NONE &&
         o_result.second_position == pmdec_pkg::POS_NONE))
        else $error("clean result carries a position");

    // A single fix names one real position and no second one.
    a_single_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == pmdec_pkg::ST_SINGLE) |->
        (o_result.first_position < pmdec_pkg::POS_NONE &&
         o_result.second_position == pmdec_pkg::POS_NONE))
        else $error("single fix positions inconsistent");

    // A double fix names two ordered positions.
    a_double_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == pmdec_pkg::ST_DOUBLE) |->
        (o_result.first_position < o_result.second_position &&
         o_result.second_position < pmdec_pkg::POS_NONE))
        else $error("double fix positions out of order");

endmodule
